### design/spsrd_pkg.sv
// ----------------------------------------------------------------------------
// spsrd_pkg
// Shared types, constants and helpers for the six-phase stepper ramp driver.
// ----------------------------------------------------------------------------
package spsrd_pkg;

  // default width of the signed remaining step count
  localparam int STEP_COUNT_BITS_DEF = 18;

  // field widths
  localparam int DEG_BITS   = 12;
  localparam int SPD_BITS   = 10;
  localparam int SPD_W_BITS = 12;
  localparam int WAIT_BITS  = 20;
  localparam int SPR_BITS   = 5;
  localparam int SHIFT_BITS = 3;
  localparam int INC_BITS   = 8;
  localparam int CFG_BITS   = 10;
  localparam int IDX_BITS   = 2;
  localparam int PROD_BITS  = DEG_BITS + SPR_BITS + 1;

  // divider of the wait computation: 1000 / speed
  localparam int DIV_BITS = 10;
  localparam int CNT_BITS = $clog2(DIV_BITS + 1);
  localparam logic [DIV_BITS-1:0] DIVIDEND = DIV_BITS'(1000);

  // constants of the ramp
  localparam logic [SPD_BITS-1:0]  SPEED_LIMIT   = SPD_BITS'(1000);
  localparam logic [WAIT_BITS-1:0] US_PER_MS     = WAIT_BITS'(1000);
  localparam logic [WAIT_BITS-1:0] START_WAIT_US = WAIT_BITS'(2000);
  localparam logic [2:0]           PHASE_LAST    = 3'd5;

  // register reset values
  localparam logic [SPR_BITS-1:0]   SPR_RESET   = SPR_BITS'(3);
  localparam logic [SPD_BITS-1:0]   MAXSP_RESET = SPD_BITS'(500);
  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = SHIFT_BITS'(3);
  localparam logic [INC_BITS-1:0]   INC_RESET   = INC_BITS'(5);

  // register indexes
  typedef enum logic [IDX_BITS-1:0] {
    REG_STEPS_PER_DEGREE = 2'd0,
    REG_MAX_SPEED        = 2'd1,
    REG_RAMP_SHIFT       = 2'd2,
    REG_SPEED_INCREMENT  = 2'd3
  } reg_idx_t;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_LOAD = 2'd2
  } state_t;

  typedef struct packed {
    logic                        cmd;
    logic signed [DEG_BITS-1:0]  move_degrees;
  } req_t;

  typedef struct packed {
    logic                  coil_ul;
    logic                  coil_ur;
    logic                  coil_com;
    logic                  stepped;
    logic                  busy_res;
    logic [WAIT_BITS-1:0]  wait_us;
  } res_t;

  // coil levels {ul, ur, com} for a phase
  function automatic logic [2:0] coil_levels(input logic [2:0] phase);
    logic [2:0] lv;
    unique case (phase)
      3'd0:    lv = 3'b110;
      3'd1:    lv = 3'b010;
      3'd2:    lv = 3'b011;
      3'd3:    lv = 3'b001;
      3'd4:    lv = 3'b101;
      3'd5:    lv = 3'b100;
      3'd6:    lv = 3'b110;
      default: lv = 3'b010;
    endcase
    return lv;
  endfunction

endpackage

### design/spsrd_div.sv
// ----------------------------------------------------------------------------
// spsrd_div
// Restoring divider, one quotient bit per cycle: quotient = 1000 / divisor.
// ----------------------------------------------------------------------------
module spsrd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [spsrd_pkg::DIV_BITS-1:0] divisor,
  output logic                          done,
  output logic [spsrd_pkg::DIV_BITS-1:0] quotient
);
  import spsrd_pkg::*;

  logic [DIV_BITS:0]   rem;
  logic [DIV_BITS-1:0] dvd;
  logic [DIV_BITS-1:0] dsr;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [DIV_BITS:0]   rem_sh;
  logic [DIV_BITS:0]   diff;
  logic                fit;

  // one trial subtraction
  always_comb begin
    rem_sh = {rem[DIV_BITS-1:0], dvd[DIV_BITS-1]};
    fit    = rem_sh >= {1'b0, dsr};
    diff   = rem_sh - {1'b0, dsr};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= DIVIDEND;
      dsr <= divisor;
    end else if (busy) begin
      rem      <= fit ? diff : rem_sh;
      dvd      <= {dvd[DIV_BITS-2:0], 1'b0};
      quotient <= {quotient[DIV_BITS-2:0], fit};
    end
  end

endmodule

### design/six_phase_stepper_ramp_driver.sv
// ----------------------------------------------------------------------------
// six_phase_stepper_ramp_driver
// Six-phase gauge stepper driver with an acceleration ramp and tick timing.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) takes a start request (cmd 0, a
//   signed move in degrees) or a timer tick (cmd 1). Every request yields
//   exactly one result on the res channel (res_valid/res_stall/res): coil
//   levels, a stepped flag, the busy flag and the wait to the next tick.
//   A tick that steps the motor runs the serial divider for 1000/speed:
//   its result passes through the divide state (S_DIV) and the load
//   state (S_LOAD) into the output register; a start or a non-stepping
//   tick goes from S_LOAD into it. req_stall stays high while a request
//   is being worked on, so one request is in flight at a time.
//   The result sits in an output register; the next request may be taken
//   while that result still waits, and a finished result is held back until
//   the output register frees up, so a stalled receiver only delays.
//   Reset (rst, synchronous) clears the move state (no move, phase 0, speed
//   0) and loads the registers with steps_per_degree 3, speed_ceiling 500,
//   ramp_shift 3, speed_increment 5. Registers are written through
//   cfg_we/cfg_index/cfg_data; the user must write them only while no
//   request is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module six_phase_stepper_ramp_driver #(
  parameter int STEP_COUNT_BITS = spsrd_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [spsrd_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [spsrd_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  spsrd_pkg::req_t                req,
  output logic                           res_valid,
  input  logic                           res_stall,
  output spsrd_pkg::res_t                res
);
  import spsrd_pkg::*;

  localparam int CW = (STEP_COUNT_BITS > PROD_BITS) ? STEP_COUNT_BITS : PROD_BITS;
  localparam logic signed [CW-1:0] LIM_HI =
    CW'((64'd1 << (STEP_COUNT_BITS - 1)) - 64'd1);
  localparam logic signed [CW-1:0] LIM_LO = -LIM_HI - CW'(1);

  // registers
  logic [SPR_BITS-1:0]   steps_per_degree;
  logic [SPD_BITS-1:0]   speed_ceiling;
  logic [SHIFT_BITS-1:0] ramp_shift;
  logic [INC_BITS-1:0]   speed_increment;

  // move state
  logic signed [STEP_COUNT_BITS-1:0] remaining;
  logic [SPD_BITS-1:0]               speed;
  logic [2:0]                        phase;
  logic                              moving;

  state_t state, state_next;
  res_t   pend;
  res_t   res_next;
  logic   accept;
  logic   res_free;
  logic   div_start;
  logic   div_done;
  logic [DIV_BITS-1:0] quotient;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [CW-1:0]        prod_ext;
  logic signed [CW-1:0]        prod_sat;
  logic [2:0]                  phase_step;
  logic [SPD_BITS-1:0]         cap;
  logic [SPD_BITS-1:0]         head;
  logic [SPD_W_BITS-1:0]       sum;
  logic [SPD_BITS-1:0]         spd_new;
  logic [DIV_BITS-1:0]         divisor;
  logic                        do_step;
  logic [WAIT_BITS-1:0]        step_wait;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_degree <= SPR_RESET;
      speed_ceiling    <= MAXSP_RESET;
      ramp_shift       <= SHIFT_RESET;
      speed_increment  <= INC_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEPS_PER_DEGREE: steps_per_degree <= cfg_data[SPR_BITS-1:0];
        REG_MAX_SPEED:        speed_ceiling    <= cfg_data[SPD_BITS-1:0];
        REG_RAMP_SHIFT:       ramp_shift       <= cfg_data[SHIFT_BITS-1:0];
        REG_SPEED_INCREMENT:  speed_increment  <= cfg_data[INC_BITS-1:0];
        default:              ;
      endcase
    end
  end

  // start count: degrees times steps per degree, saturated
  always_comb begin
    prod     = PROD_BITS'(req.move_degrees) * $signed({1'b0, steps_per_degree});
    prod_ext = CW'(prod);
    if (prod_ext > LIM_HI)      prod_sat = LIM_HI;
    else if (prod_ext < LIM_LO) prod_sat = LIM_LO;
    else                        prod_sat = prod_ext;
  end

  // phase step and speed ramp
  always_comb begin
    if (!remaining[STEP_COUNT_BITS-1]) begin
      phase_step = (phase == PHASE_LAST) ? 3'd0 : phase + 3'd1;
    end else begin
      phase_step = (phase == 3'd0) ? PHASE_LAST : phase - 3'd1;
    end
    if (speed_ceiling == '0)              cap = SPD_BITS'(1);
    else if (speed_ceiling > SPEED_LIMIT) cap = SPEED_LIMIT;
    else                                  cap = speed_ceiling;
    head    = (cap > speed) ? ((cap - speed) >> ramp_shift) : '0;
    sum     = SPD_W_BITS'(speed) + SPD_W_BITS'(head) + SPD_W_BITS'(speed_increment);
    spd_new = (sum > SPD_W_BITS'(cap)) ? cap : sum[SPD_BITS-1:0];
    divisor = (spd_new == '0) ? DIV_BITS'(1) : spd_new;
  end

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign do_step   = (req.cmd == CMD_TICK) && moving && (remaining != '0);
  assign div_start = accept && do_step;
  assign res_free  = !res_valid || !res_stall;
  assign step_wait = WAIT_BITS'(quotient) * US_PER_MS;

  spsrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // move state update on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      speed     <= '0;
      phase     <= '0;
      moving    <= 1'b0;
    end else if (accept) begin
      priority if (req.cmd == CMD_START) begin
        remaining <= STEP_COUNT_BITS'(prod_sat);
        speed     <= '0;
        moving    <= 1'b1;
      end else if (!moving) begin
      end else if (remaining == '0) begin
        moving <= 1'b0;
      end else begin
        phase <= phase_step;
        speed <= spd_new;
        if (!remaining[STEP_COUNT_BITS-1]) remaining <= remaining - 1'b1;
        else                               remaining <= remaining + 1'b1;
      end
    end
  end

  // pending result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      priority if (req.cmd == CMD_START) begin
        {pend.coil_ul, pend.coil_ur, pend.coil_com} <= coil_levels(phase);
        pend.stepped  <= 1'b0;
        pend.busy_res <= 1'b1;
        pend.wait_us  <= START_WAIT_US;
      end else if (do_step) begin
        {pend.coil_ul, pend.coil_ur, pend.coil_com} <= coil_levels(phase_step);
        pend.stepped  <= 1'b1;
        pend.busy_res <= 1'b1;
        pend.wait_us  <= '0;
      end else begin
        {pend.coil_ul, pend.coil_ur, pend.coil_com} <= coil_levels(phase);
        pend.stepped  <= 1'b0;
        pend.busy_res <= 1'b0;
        pend.wait_us  <= '0;
      end
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = do_step ? S_DIV : S_LOAD;
      end
      S_DIV: begin
        if (div_done) state_next = S_LOAD;
      end
      S_LOAD: begin
        if (res_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_LOAD && res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // result with the divided wait for a step
  always_comb begin
    res_next = pend;
    if (pend.stepped) res_next.wait_us = step_wait;
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && res_free) begin
      res <= res_next;
    end
  end

  // checks
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PHASE_LAST) else $error("coil phase out of range");

  a_speed_cap: assert property (@(posedge clk) disable iff (rst)
    speed <= SPEED_LIMIT) else $error("speed above limit");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !moving |-> remaining == '0) else $error("steps left with no move");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("divider done outside divide state");

endmodule
